// File: rtl/core/gdps_pkg.sv
// Shared types and constants for the greedy distance point suppression unit.
// No dependencies; imported by every module of the block.
package gdps_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 8;
    localparam int SIZE_W   = 12;
    localparam int FRAC_W   = 4;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;
    // 8*R*R pixels^2 in 1/256 pixel^2 units is R*R shifted left by 11.
    localparam int THR_SHIFT = 11;
    localparam int THR_W     = 2 * RADIUS_W + THR_SHIFT;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_REGION_RADIUS = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd16;
    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 12'd480;

    // One classified point on its way from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               first_of_set;
        logic               at_border;
    } point_t;

    typedef struct packed {
        logic store_overflow;
        logic at_border;
        logic near_kept;
        logic keep;
    } result_t;

endpackage

// File: rtl/core/gdps_front.sv
// Front end: takes input transfers, runs the image border test and holds one point.
// Depends on gdps_pkg.
module gdps_front
    import gdps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [COORD_W-1:0]  in_pos_x,
    input  logic [COORD_W-1:0]  in_pos_y,
    input  logic                in_first,
    input  logic [RADIUS_W-1:0] region_radius,
    input  logic [SIZE_W-1:0]   image_width,
    input  logic [SIZE_W-1:0]   image_height,
    output logic                push,
    output point_t              push_point,
    input  logic                queue_full
);

    logic                  valid_reg;
    logic                  valid_next;
    point_t                point_reg;
    logic                  accept;
    logic                  border;
    logic [COORD_W-1:0]    r16;
    logic [COORD_W-1:0]    w16;
    logic [COORD_W-1:0]    h16;
    logic [COORD_W:0]      x_plus_r;
    logic [COORD_W:0]      y_plus_r;

    assign push     = valid_reg && !queue_full;
    assign s_tready = !valid_reg || push;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        r16      = {{(COORD_W - RADIUS_W - FRAC_W){1'b0}}, region_radius, {FRAC_W{1'b0}}};
        w16      = {image_width, {FRAC_W{1'b0}}};
        h16      = {image_height, {FRAC_W{1'b0}}};
        x_plus_r = {1'b0, in_pos_x} + {1'b0, r16};
        y_plus_r = {1'b0, in_pos_y} + {1'b0, r16};
        // width - x < r is rewritten as width < x + r to stay unsigned.
        border = (in_pos_x < r16) || (in_pos_y < r16) ||
                 ({1'b0, w16} < x_plus_r) || ({1'b0, h16} < y_plus_r);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            point_reg.pos_x        <= in_pos_x;
            point_reg.pos_y        <= in_pos_y;
            point_reg.first_of_set <= in_first;
            point_reg.at_border    <= border;
        end
    end

    assign push_point = point_reg;

endmodule

// File: rtl/core/gdps_queue.sv
// Small FIFO of classified points between the front and the back.
// Depends on gdps_pkg.
module gdps_queue
    import gdps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  point_t push_point,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output point_t head_point
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    point_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_point = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_point;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more entries than its depth");
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && !not_empty))
        else $error("queue popped while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

// File: rtl/core/gdps_back.sv
// Back end: scans the survivor store for each point, stores survivors, holds the result.
// Depends on gdps_pkg; the survivor store memory lives here.
module gdps_back
    import gdps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  point_t              q_point,
    output logic                q_pop,
    input  logic [RADIUS_W-1:0] region_radius,
    output logic                m_valid,
    input  logic                m_ready,
    output result_t             m_result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    scan_cnt_next;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    rd_idx_next;
    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic                near_reg;
    logic                near_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    result_t             m_result_reg;
    point_t              point_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [2*RADIUS_W-1:0] r_sq;
    logic [COORD_W-1:0]  kept_x [MAX_POINTS];
    logic [COORD_W-1:0]  kept_y [MAX_POINTS];
    logic [COORD_W-1:0]  rd_x_reg;
    logic [COORD_W-1:0]  rd_y_reg;
    logic [SQ_W-1:0]     dx2_reg;
    logic [SQ_W-1:0]     dy2_reg;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [DIST_W-1:0]   dist2;
    logic                rd_en;
    logic                out_load;
    logic                has_room;
    logic                store_we;

    assign has_room = (count_reg < CNT_W'(MAX_POINTS));
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign rd_en    = (state_reg == ST_SCAN) && (rd_idx_reg < scan_cnt_reg);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign store_we = out_load && !near_reg && has_room;
    assign r_sq     = region_radius * region_radius;

    always_comb begin
        dx    = (point_reg.pos_x >= rd_x_reg) ? point_reg.pos_x - rd_x_reg
                                              : rd_x_reg - point_reg.pos_x;
        dy    = (point_reg.pos_y >= rd_y_reg) ? point_reg.pos_y - rd_y_reg
                                              : rd_y_reg - point_reg.pos_y;
        dist2 = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_idx_next   = rd_idx_reg;
        near_next     = near_reg;
        m_valid_next  = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    // A first point empties the store before it is judged.
                    if (q_point.first_of_set) begin
                        count_next    = '0;
                        scan_cnt_next = '0;
                    end else begin
                        scan_cnt_next = count_reg;
                    end
                    rd_idx_next = '0;
                    near_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (s2_valid_reg && (dist2 < DIST_W'(thr_reg))) begin
                    near_next = 1'b1;
                end
                if (!rd_en && !s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (store_we) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            near_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_idx_reg   <= rd_idx_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            near_reg     <= near_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Point, threshold, distance pipeline and result payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            point_reg <= q_point;
            thr_reg   <= {r_sq, {THR_SHIFT{1'b0}}};
        end
        dx2_reg <= dx * dx;
        dy2_reg <= dy * dy;
        if (out_load) begin
            m_result_reg.near_kept      <= near_reg;
            m_result_reg.at_border      <= point_reg.at_border;
            m_result_reg.keep           <= !near_reg && !point_reg.at_border;
            m_result_reg.store_overflow <= !near_reg && !has_room;
        end
    end

    // Survivor store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            kept_x[count_reg[IDX_W-1:0]] <= point_reg.pos_x;
            kept_y[count_reg[IDX_W-1:0]] <= point_reg.pos_y;
        end
        if (rd_en) begin
            rd_x_reg <= kept_x[rd_idx_reg[IDX_W-1:0]];
            rd_y_reg <= kept_y[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(MAX_POINTS))
        else $error("survivor count beyond store size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg == count_reg))
        else $error("scan length differs from survivor count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == ST_SCAN))
        else $error("distance pipeline busy outside the scan");
`endif

endmodule

// File: rtl/core/greedy_distance_point_suppression_unit.sv
// Top level of the greedy distance point suppression unit: configuration registers,
// front end, point queue and back end. Depends on gdps_pkg, gdps_front, gdps_queue, gdps_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  tdata: pos_x, pos_y; tuser: first_of_set
//   m_        out        m_tvalid/m_tready  tdata: keep; tuser: near_kept, at_border, overflow
//   APB       in         psel/penable       radius, width, height at 0x0, 0x4, 0x8
//
// In the back end the survivor scan reads one stored point per cycle from the single
// memory read port, at most MAX_POINTS of them; nothing is scanned for a first point or
// an empty store.
// The front end and a two-entry queue take further points while the back end scans.
// Reset is synchronous and active low; it empties the store and the queue. No clearing
// pass is needed. A stalled result waits in the output register without losing points.
module greedy_distance_point_suppression_unit
    import gdps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] pos_x, [31:16] pos_y
    input  logic [0:0]            s_tuser,   // [0] first_of_set
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] keep, [7:1] zero
    output logic [2:0]            m_tuser,   // [0] near_kept, [1] at_border, [2] store_overflow
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [RADIUS_W-1:0] region_radius_reg;
    logic [SIZE_W-1:0]   image_width_reg;
    logic [SIZE_W-1:0]   image_height_reg;
    logic                cfg_write;
    logic [1:0]          reg_index;
    logic                push;
    point_t              push_point;
    logic                queue_full;
    logic                pop;
    logic                queue_not_empty;
    point_t              head_point;
    result_t             result;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_radius_reg <= RADIUS_RESET;
            image_width_reg   <= WIDTH_RESET;
            image_height_reg  <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_REGION_RADIUS: region_radius_reg <= pwdata[RADIUS_W-1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_REGION_RADIUS: prdata = {{(APB_DATA_W - RADIUS_W){1'b0}}, region_radius_reg};
            REG_IMAGE_WIDTH:   prdata = {{(APB_DATA_W - SIZE_W){1'b0}}, image_width_reg};
            REG_IMAGE_HEIGHT:  prdata = {{(APB_DATA_W - SIZE_W){1'b0}}, image_height_reg};
            default:           prdata = '0;
        endcase
    end

    gdps_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_pos_x      (s_tdata[15:0]),
        .in_pos_y      (s_tdata[31:16]),
        .in_first      (s_tuser[0]),
        .region_radius (region_radius_reg),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .push          (push),
        .push_point    (push_point),
        .queue_full    (queue_full)
    );

    gdps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_point (push_point),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head_point (head_point)
    );

    gdps_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (queue_not_empty),
        .q_point       (head_point),
        .q_pop         (pop),
        .region_radius (region_radius_reg),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_result      (result)
    );

    assign m_tdata = {7'b0, result.keep};
    assign m_tuser = {result.store_overflow, result.at_border, result.near_kept};

endmodule
